// File: rtl/cigar_span_and_identity_macros.svh
// ----------------------------------------------------------------------------
// cigar_span_and_identity_macros.svh
// Assertion macros shared by the CIGAR span and identity block.
// ----------------------------------------------------------------------------
`ifndef CIGAR_SPAN_AND_IDENTITY_MACROS_SVH
`define CIGAR_SPAN_AND_IDENTITY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CSI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CSI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/csi_pkg.sv
// ----------------------------------------------------------------------------
// csi_pkg
// Types, codes and constants of the CIGAR span and identity block.
// ----------------------------------------------------------------------------
package csi_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	// operation codes, BAM order
	localparam logic [3:0] OP_M  = 4'd0;
	localparam logic [3:0] OP_I  = 4'd1;
	localparam logic [3:0] OP_D  = 4'd2;
	localparam logic [3:0] OP_S  = 4'd4;
	localparam logic [3:0] OP_H  = 4'd5;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X  = 4'd8;

	// register map
	localparam int          PADDR_W         = 3;
	localparam logic [2:0]  REG_SHORT_INDEL = 3'd0;
	localparam logic [2:0]  REG_MIN_ALIGNED = 3'd4;
	localparam logic [7:0]  SHORT_INDEL_RST = 8'd8;
	localparam logic [15:0] MIN_ALIGNED_RST = 16'd50;

	// identity: 100 percent with 8 fraction bits
	localparam int          ID_W        = 15;
	localparam logic [14:0] ID_FULL     = 15'd25600;
	localparam int          DIV_STEPS   = ID_W;
	localparam int          DIV_CNT_W   = 4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CAPTURE,
		S_DIV,
		S_DONE
	} csi_state_t;

	typedef struct packed {
		logic accum;
		logic capture;
		logic div_step;
		logic load_out;
	} csi_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} csi_status_t;

endpackage

// File: rtl/csi_ctrl.sv
// ----------------------------------------------------------------------------
// csi_ctrl
// Sequencer: accumulate ops, then capture, divide and hand off one result.
// ----------------------------------------------------------------------------
`include "cigar_span_and_identity_macros.svh"

module csi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  csi_pkg::csi_status_t status,
	output csi_pkg::csi_cmd_t    cmd
);
	import csi_pkg::*;

	csi_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_last) state_d = S_CAPTURE;
			end
			S_CAPTURE: state_d = S_DIV;
			S_DIV: begin
				if (status.div_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.accum = in_valid;
			end
			S_CAPTURE: cmd.capture = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_DONE: cmd.load_out = status.out_free;
			default: cmd = '0;
		endcase
	end

	`CSI_ASSERT_NEXT(a_capture_then_div, state_q == S_CAPTURE, state_q == S_DIV,
		"capture not followed by divide")
	`CSI_ASSERT_IMPL(a_load_needs_room, cmd.load_out, status.out_free,
		"result loaded over a pending transaction")

endmodule

// File: rtl/csi_dp.sv
// ----------------------------------------------------------------------------
// csi_dp
// Saturating totals, result capture, shift-subtract divider, output register.
// ----------------------------------------------------------------------------
`include "cigar_span_and_identity_macros.svh"

module csi_dp #(
	parameter int COUNT_WIDTH = csi_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csi_pkg::csi_cmd_t    cmd,
	output csi_pkg::csi_status_t status,
	input  logic [3:0]           op_code,
	input  logic [27:0]          op_length,
	input  logic                 reverse_strand,
	input  logic [7:0]           short_indel_limit,
	input  logic [15:0]          min_aligned_size,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          query_offset,
	output logic [31:0]          fragment_size,
	output logic [14:0]          identity_percent
);
	import csi_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int SW = ((CW > 28) ? CW : 28) + 1;
	localparam int EW = ((CW > 32) ? CW : 32) + 1;
	localparam int NW = CW + 17;
	localparam logic [CW-1:0] COUNT_MAX = '1;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [27:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		sat_add = (s > SW'(COUNT_MAX)) ? COUNT_MAX : s[CW-1:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [CW-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		sat32 = (e > EW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	// running totals
	logic          at_first_q;
	logic [CW-1:0] qt_q, lead_q, aqe_q, as_q, mt_q, ft_q;
	logic [CW-1:0] qt_d, lead_d, aqe_d, as_d, mt_d, ft_d;
	logic          rev_q;

	logic          short_indel, lead_s;
	logic [CW-1:0] len_sat, aqe_base;

	always_comb begin
		short_indel = op_length < 28'(short_indel_limit);
		lead_s      = at_first_q && (op_code == OP_S);
		len_sat     = sat_add('0, op_length);
		aqe_base    = lead_s ? len_sat : aqe_q;
		lead_d      = lead_s ? len_sat : lead_q;
		qt_d  = qt_q;
		aqe_d = aqe_base;
		as_d  = as_q;
		mt_d  = mt_q;
		ft_d  = ft_q;
		unique case (op_code)
			OP_M, OP_EQ: begin
				as_d  = sat_add(as_q, op_length);
				mt_d  = sat_add(mt_q, op_length);
				ft_d  = sat_add(ft_q, op_length);
				aqe_d = sat_add(aqe_base, op_length);
				qt_d  = sat_add(qt_q, op_length);
			end
			OP_X: begin
				as_d  = sat_add(as_q, op_length);
				ft_d  = sat_add(ft_q, op_length);
				aqe_d = sat_add(aqe_base, op_length);
				qt_d  = sat_add(qt_q, op_length);
			end
			OP_I: begin
				if (short_indel) as_d = sat_add(as_q, op_length);
				ft_d  = sat_add(ft_q, op_length);
				aqe_d = sat_add(aqe_base, op_length);
				qt_d  = sat_add(qt_q, op_length);
			end
			OP_D: begin
				if (short_indel) as_d = sat_add(as_q, op_length);
			end
			OP_S, OP_H: qt_d = sat_add(qt_q, op_length);
			default: qt_d = qt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_first_q <= 1'b1;
			qt_q   <= '0;
			lead_q <= '0;
			aqe_q  <= '0;
			as_q   <= '0;
			mt_q   <= '0;
			ft_q   <= '0;
			rev_q  <= 1'b0;
		end else if (cmd.capture) begin
			at_first_q <= 1'b1;
			qt_q   <= '0;
			lead_q <= '0;
			aqe_q  <= '0;
			as_q   <= '0;
			mt_q   <= '0;
			ft_q   <= '0;
		end else if (cmd.accum) begin
			at_first_q <= 1'b0;
			qt_q   <= qt_d;
			lead_q <= lead_d;
			aqe_q  <= aqe_d;
			as_q   <= as_d;
			mt_q   <= mt_d;
			ft_q   <= ft_d;
			rev_q  <= reverse_strand;
		end
	end

	// capture: offsets, numerator m*51200 + a, divisor 2a aligned to quotient msb
	logic [CW-1:0] m_clamp, rev_off;
	logic [NW-1:0] m_ext, numer;
	logic          small_aln;

	always_comb begin
		m_clamp   = (mt_q > as_q) ? as_q : mt_q;
		m_ext     = NW'(m_clamp);
		numer     = (m_ext << 15) + (m_ext << 14) + (m_ext << 11) + NW'(as_q);
		rev_off   = (qt_q > aqe_q) ? (qt_q - aqe_q) : '0;
		small_aln = (as_q == '0) || (as_q < CW'(min_aligned_size));
	end

	logic [31:0]          off_q, frag_q;
	logic                 small_q;
	logic [NW-1:0]        rem_q, dsh_q;
	logic [ID_W-1:0]      quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			off_q   <= sat32(rev_q ? rev_off : lead_q);
			frag_q  <= sat32(ft_q);
			small_q <= small_aln;
			rem_q   <= numer;
			dsh_q   <= NW'({as_q, 1'b0}) << (DIV_STEPS - 1);
			quot_q  <= '0;
			cnt_q   <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q  <= rem_q - dsh_q;
				quot_q <= {quot_q[ID_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[ID_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			query_offset     <= off_q;
			fragment_size    <= frag_q;
			identity_percent <= small_q ? '0 : quot_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.div_last = (cnt_q == '0);
	assign status.out_free = !out_valid_q || out_ready;

	`CSI_ASSERT_NEXT(a_load_shows_valid, cmd.load_out, out_valid_q,
		"loaded result not presented")
	`CSI_ASSERT_IMPL(a_identity_range, out_valid_q, identity_percent <= ID_FULL,
		"identity above 100 percent")
	`CSI_ASSERT_NEXT(a_capture_rearms, cmd.capture, at_first_q && (as_q == '0),
		"totals not cleared after record")

endmodule

// File: rtl/cigar_span_and_identity.sv
// ----------------------------------------------------------------------------
// cigar_span_and_identity
// Per-record CIGAR totals: query offset, fragment size and percent identity.
// An op that is not last is taken while ready is high, and ready stays high after it.
// A last op is accumulated too; ready then stays low through capture, the
// one-bit-per-cycle identity divider and the hand-off to the output register.
// The hand-off waits until that register is free; the result then shows on m_axis.
// Reset (arst_n low): totals cleared, registers at 8 and 50, no result pending.
// ----------------------------------------------------------------------------
`include "cigar_span_and_identity_macros.svh"

module cigar_span_and_identity #(
	parameter int COUNT_WIDTH = csi_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// op stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // op_code[3:0], op_length[31:4]
	input  logic                        s_axis_tuser,  // reverse_strand
	input  logic                        s_axis_tlast,  // last_op
	// result stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [79:0]                 m_axis_tdata,  // query_offset[31:0],
	                                                   // fragment_size[63:32],
	                                                   // identity_percent[78:64], zero
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csi_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import csi_pkg::*;

	// Registers: short_indel_limit at 0x0, min_aligned_size at 0x4.
	logic [7:0]  short_indel_limit_q;
	logic [15:0] min_aligned_size_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_indel_limit_q <= SHORT_INDEL_RST;
			min_aligned_size_q  <= MIN_ALIGNED_RST;
		end else if (cfg_wr) begin
			if (paddr == REG_SHORT_INDEL) short_indel_limit_q <= pwdata[7:0];
			if (paddr == REG_MIN_ALIGNED) min_aligned_size_q  <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (paddr)
			REG_SHORT_INDEL: prdata = 32'(short_indel_limit_q);
			REG_MIN_ALIGNED: prdata = 32'(min_aligned_size_q);
			default:         prdata = '0;
		endcase
	end

	// Controller and datapath talk only through cmd / status.
	csi_cmd_t    cmd;
	csi_status_t status;

	csi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	logic [31:0] query_offset, fragment_size;
	logic [14:0] identity_percent;

	csi_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.op_code           (s_axis_tdata[3:0]),
		.op_length         (s_axis_tdata[31:4]),
		.reverse_strand    (s_axis_tuser),
		.short_indel_limit (short_indel_limit_q),
		.min_aligned_size  (min_aligned_size_q),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.query_offset      (query_offset),
		.fragment_size     (fragment_size),
		.identity_percent  (identity_percent)
	);

	assign m_axis_tdata = {1'b0, identity_percent, fragment_size, query_offset};

	// A transaction is only taken while the sequencer sits between records.
	`CSI_ASSERT_IMPL(a_no_take_in_divide, s_axis_tready, !cmd.div_step && !cmd.capture,
		"op transaction accepted during result computation")

endmodule
